// ===== hw/rtl/freq_indexed_coeff_interp_table_defines.svh =====
`ifndef FREQ_INDEXED_COEFF_INTERP_TABLE_DEFINES_SVH
`define FREQ_INDEXED_COEFF_INTERP_TABLE_DEFINES_SVH

// Assertion helpers. The using scope provides clk and rst_n.

// The consequent must hold in the same cycle as the antecedent.
`define FICT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fict assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FICT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fict assertion failed");

`endif

// ===== hw/rtl/fict_pkg.sv =====
package fict_pkg;

    localparam int KEY_W   = 40;
    localparam int CO_W    = 32;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int DIFF_W  = CO_W + 1;
    localparam int QUOT_W  = CO_W + 2;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic signed [CO_W-1:0] re;
        logic signed [CO_W-1:0] im;
    } entry_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] d;
        logic [KEY_W-1:0]         n;
        logic [KEY_W-1:0]         den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [QUOT_W-1:0] q;
    } div_rsp_t;

endpackage

// ===== hw/rtl/fict_req_if.sv =====
interface fict_req_if;
    import fict_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [KEY_W-1:0]         freq_hz;
    logic signed [CO_W-1:0]   coeff_in_real;
    logic signed [CO_W-1:0]   coeff_in_imag;

    modport source (output valid, req_type, freq_hz, coeff_in_real, coeff_in_imag,
                    input ready);
    modport sink   (input valid, req_type, freq_hz, coeff_in_real, coeff_in_imag,
                    output ready);
endinterface

// ===== hw/rtl/fict_rsp_if.sv =====
interface fict_rsp_if;
    import fict_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CO_W-1:0]   coeff_out_real;
    logic signed [CO_W-1:0]   coeff_out_imag;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;

    modport source (output valid, coeff_out_real, coeff_out_imag, status, entry_count,
                    input ready);
    modport sink   (input valid, coeff_out_real, coeff_out_imag, status, entry_count,
                    output ready);
endinterface

// ===== hw/rtl/fict_div.sv =====
// Serial scaled divider: floor(d * n / den) for 0 <= n < den, one bit of |d| at a time.
module fict_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fict_pkg::div_req_t req,
    output fict_pkg::div_rsp_t rsp
);
    import fict_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_ADD, D_SUB, D_FIN} dstate_t;

    dstate_t              state_reg, state_next;
    logic [DIFF_W-1:0]    mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [KEY_W-1:0]     n_reg, n_next;
    logic [KEY_W-1:0]     den_reg, den_next;
    logic [KEY_W+1:0]     t_reg, t_next;
    logic [KEY_W-1:0]     r_reg, r_next;
    logic [DIFF_W-1:0]    q_reg, q_next;
    logic [5:0]           bit_reg, bit_next;
    logic                 done_reg, done_next;
    logic [QUOT_W-1:0]    res_reg, res_next;
    logic [KEY_W+1:0]     den1, den2;
    logic [QUOT_W-1:0]    q_ext;

    assign den1  = {2'b00, den_reg};
    assign den2  = {1'b0, den_reg, 1'b0};
    assign q_ext = {1'b0, q_reg};

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        n_next     = n_reg;
        den_next   = den_reg;
        t_next     = t_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    neg_next   = req.d[DIFF_W-1];
                    mag_next   = req.d[DIFF_W-1] ? DIFF_W'(-req.d) : DIFF_W'(req.d);
                    n_next     = req.n;
                    den_next   = req.den;
                    r_next     = '0;
                    q_next     = '0;
                    bit_next   = 6'(DIFF_W - 1);
                    state_next = D_ADD;
                end
            end
            D_ADD:
            begin
                t_next     = {r_reg, 1'b0} + (mag_reg[DIFF_W-1] ? {2'b00, n_reg} : '0);
                mag_next   = {mag_reg[DIFF_W-2:0], 1'b0};
                q_next     = {q_reg[DIFF_W-2:0], 1'b0};
                state_next = D_SUB;
            end
            D_SUB:
            begin
                if (t_reg >= den2)
                begin
                    r_next = KEY_W'(t_reg - den2);
                    q_next = q_reg + DIFF_W'(2);
                end
                else if (t_reg >= den1)
                begin
                    r_next = KEY_W'(t_reg - den1);
                    q_next = q_reg + DIFF_W'(1);
                end
                else
                begin
                    r_next = KEY_W'(t_reg);
                end
                if (bit_reg == '0)
                begin
                    state_next = D_FIN;
                end
                else
                begin
                    bit_next   = bit_reg - 6'd1;
                    state_next = D_ADD;
                end
            end
            D_FIN:
            begin
                res_next   = neg_reg ? (-q_ext - QUOT_W'(r_reg != '0)) : q_ext;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        n_reg   <= n_next;
        den_reg <= den_next;
        t_reg   <= t_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = res_reg;

endmodule

// ===== hw/rtl/freq_indexed_coeff_interp_table.sv =====
// Frequency-indexed coefficient table. Each request word on req is one of lookup, insert
// or clear, and every request returns exactly one response word on rsp carrying the
// coefficient (zero unless it is a lookup), a status code and the entry count after the
// request. Entries live in one memory of TABLE_DEPTH words kept sorted by frequency.
// The block handles one request at a time and drops req.ready from acceptance until its
// response is loaded into the output register. Timing is set by a linear scan of that
// memory, one read and compare per entry examined, and, for interpolation, by one shared
// serial divider that holds the sequencer for the real and then the imaginary part; an
// insert also shifts every entry above the insertion point up one slot.
// The mode register (0 interpolate, 1 nearest) is written through cfg_wr_en.
module freq_indexed_coeff_interp_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    fict_req_if.sink   req,
    fict_rsp_if.source rsp,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);
    import fict_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // The sequencer: scan, decide, maybe divide, pick the nearer entry or shift, then present.
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CMP, S_POST, S_SPAN, S_NEAR,
        S_DRE_GO, S_DRE_WAIT, S_DIM_GO, S_DIM_WAIT,
        S_SH_RD, S_SH_WR, S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [REQ_W-1:0]        rtype_reg, rtype_next;
    logic [KEY_W-1:0]        freq_reg, freq_next;
    logic signed [CO_W-1:0]  cin_re_reg, cin_re_next;
    logic signed [CO_W-1:0]  cin_im_reg, cin_im_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           k_reg, k_next;
    entry_t                  lo_reg, lo_next;
    entry_t                  hi_reg, hi_next;
    logic [KEY_W-1:0]        n_reg, n_next;
    logic [KEY_W-1:0]        den_reg, den_next;
    logic signed [CO_W-1:0]  res_re_reg, res_re_next;
    logic signed [CO_W-1:0]  res_im_reg, res_im_next;
    logic [STAT_W-1:0]       stat_reg, stat_next;
    logic                    mode_reg;
    logic                    ovalid_reg, ovalid_next;
    logic signed [CO_W-1:0]  ore_reg, ore_next;
    logic signed [CO_W-1:0]  oim_reg, oim_next;
    logic [STAT_W-1:0]       ostat_reg, ostat_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;

    entry_t                  mem [TABLE_DEPTH];
    entry_t                  rd_q;
    logic                    rd_en;
    logic [IW-1:0]           rd_addr;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    entry_t                  wr_data;

    div_req_t                dreq;
    div_rsp_t                drsp;
    logic [CW+CNT_W-1:0]     cnt_ext;

    assign cnt_ext = {{CNT_W{1'b0}}, count_next};

    // Only the entry parts are shared with the divider; the start flag follows the state.
    always_comb
    begin
        dreq.start = (state_reg == S_DRE_GO) || (state_reg == S_DIM_GO);
        dreq.n     = n_reg;
        dreq.den   = den_reg;
        if (state_reg == S_DIM_GO)
        begin
            dreq.d = $signed({hi_reg.im[CO_W-1], hi_reg.im})
                   - $signed({lo_reg.im[CO_W-1], lo_reg.im});
        end
        else
        begin
            dreq.d = $signed({hi_reg.re[CO_W-1], hi_reg.re})
                   - $signed({lo_reg.re[CO_W-1], lo_reg.re});
        end
    end

    fict_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        rtype_next  = rtype_reg;
        freq_next   = freq_reg;
        cin_re_next = cin_re_reg;
        cin_im_next = cin_im_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        n_next      = n_reg;
        den_next    = den_reg;
        res_re_next = res_re_reg;
        res_im_next = res_im_reg;
        stat_next   = stat_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        ore_next    = ore_reg;
        oim_next    = oim_reg;
        ostat_next  = ostat_reg;
        ocnt_next   = ocnt_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = idx_reg[IW-1:0];
        wr_data     = '{key: freq_reg, re: cin_re_reg, im: cin_im_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rtype_next  = req.req_type;
                    freq_next   = req.freq_hz;
                    cin_re_next = req.coeff_in_real;
                    cin_im_next = req.coeff_in_imag;
                    res_re_next = '0;
                    res_im_next = '0;
                    stat_next   = STAT_OK;
                    idx_next    = '0;
                    case (req.req_type)
                        REQ_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        REQ_INSERT:
                        begin
                            state_next = S_RD;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                // Running off the end leaves idx at the count: the key is above all entries.
                if (idx_reg == count_reg)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_q.key >= freq_reg)
                begin
                    hi_next    = rd_q;
                    state_next = S_POST;
                end
                else
                begin
                    lo_next    = rd_q;
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            S_POST:
            begin
                if (rtype_reg == REQ_LOOKUP)
                begin
                    if (idx_reg == count_reg)
                    begin
                        res_re_next = lo_reg.re;
                        res_im_next = lo_reg.im;
                        state_next  = S_OUT;
                    end
                    else if (idx_reg == '0 || hi_reg.key == freq_reg)
                    begin
                        res_re_next = hi_reg.re;
                        res_im_next = hi_reg.im;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        n_next     = freq_reg - lo_reg.key;
                        den_next   = hi_reg.key - lo_reg.key;
                        state_next = mode_reg ? S_NEAR : S_DRE_GO;
                    end
                end
                else if (idx_reg != count_reg && hi_reg.key == freq_reg)
                begin
                    // Overwrite in place, even when the table is full.
                    wr_en      = 1'b1;
                    state_next = S_OUT;
                end
                else if (count_reg == CW'(TABLE_DEPTH))
                begin
                    stat_next  = STAT_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = count_reg;
                    state_next = S_SH_RD;
                end
            end
            S_NEAR:
            begin
                // A tie goes to the lower entry.
                if ((den_reg - n_reg) < n_reg)
                begin
                    res_re_next = hi_reg.re;
                    res_im_next = hi_reg.im;
                end
                else
                begin
                    res_re_next = lo_reg.re;
                    res_im_next = lo_reg.im;
                end
                state_next = S_OUT;
            end
            S_DRE_GO:
            begin
                state_next = S_DRE_WAIT;
            end
            S_DRE_WAIT:
            begin
                if (drsp.done)
                begin
                    res_re_next = lo_reg.re + drsp.q[CO_W-1:0];
                    state_next  = S_DIM_GO;
                end
            end
            S_DIM_GO:
            begin
                state_next = S_DIM_WAIT;
            end
            S_DIM_WAIT:
            begin
                if (drsp.done)
                begin
                    res_im_next = lo_reg.im + drsp.q[CO_W-1:0];
                    state_next  = S_OUT;
                end
            end
            S_SH_RD:
            begin
                // Move entries up one slot from the top down to the insertion point.
                if (k_reg == idx_reg)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IW'(k_reg - CW'(1));
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = k_reg[IW-1:0];
                wr_data    = rd_q;
                k_next     = k_reg - CW'(1);
                state_next = S_SH_RD;
            end
            S_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ore_next    = res_re_reg;
                    oim_next    = res_im_reg;
                    ostat_next  = stat_reg;
                    ocnt_next   = cnt_ext[CNT_W-1:0];
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            mode_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rtype_reg  <= rtype_next;
        freq_reg   <= freq_next;
        cin_re_reg <= cin_re_next;
        cin_im_reg <= cin_im_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        n_reg      <= n_next;
        den_reg    <= den_next;
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        stat_reg   <= stat_next;
        ore_reg    <= ore_next;
        oim_reg    <= oim_next;
        ostat_reg  <= ostat_next;
        ocnt_reg   <= ocnt_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = ovalid_reg;
    assign rsp.coeff_out_real = ore_reg;
    assign rsp.coeff_out_imag = oim_reg;
    assign rsp.status         = ostat_reg;
    assign rsp.entry_count    = ocnt_reg;

endmodule

// ===== hw/rtl/fict_checker.sv =====
`include "freq_indexed_coeff_interp_table_defines.svh"

module fict_checker #(
    parameter int DEPTH = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic signed [fict_pkg::CO_W-1:0]   coeff_out_real,
    input logic signed [fict_pkg::CO_W-1:0]   coeff_out_imag,
    input logic [fict_pkg::STAT_W-1:0]   status,
    input logic [fict_pkg::CNT_W-1:0]    entry_count
);
    import fict_pkg::*;

    `FICT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `FICT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
    `FICT_ASSERT_SAME(a_err_zero, rsp_valid && status != STAT_OK, coeff_out_real == '0 && coeff_out_imag == '0)
    `FICT_ASSERT_SAME(a_status_code, rsp_valid, status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL)
    `FICT_ASSERT_SAME(a_count_bound, rsp_valid && DEPTH < 128, int'(entry_count) <= DEPTH)

endmodule

bind freq_indexed_coeff_interp_table fict_checker #(.DEPTH(TABLE_DEPTH)) u_fict_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .coeff_out_real (rsp.coeff_out_real),
    .coeff_out_imag (rsp.coeff_out_imag),
    .status         (rsp.status),
    .entry_count    (rsp.entry_count)
);

// ===== tb/freq_indexed_coeff_interp_table_test.sv =====
`timescale 1ns / 1ps

module freq_indexed_coeff_interp_table_test;
    import fict_pkg::*;

    localparam int DEPTH = 64;
    // A request may scan and shift the whole table, or scan it and run two serial divides;
    // the watchdog allows far more than the longest such request plus the longest receiver
    // hold-off.
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    // The fourth request code has no meaning and must act as a no-op.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [CO_W-1:0] re;
        logic signed [CO_W-1:0] im;
        logic [STAT_W-1:0]      status;
        logic [CNT_W-1:0]       count;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    fict_req_if req_bus ();
    fict_rsp_if rsp_bus ();

    freq_indexed_coeff_interp_table #(.TABLE_DEPTH(DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_bus.sink),
        .rsp(rsp_bus.source),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Shadow copy of the table and the mode register.
    logic [KEY_W-1:0]       shadow_key [DEPTH];
    logic signed [CO_W-1:0] shadow_re  [DEPTH];
    logic signed [CO_W-1:0] shadow_im  [DEPTH];
    int                     shadow_used;
    logic                   shadow_nearest;

    answer_t pending_answers[$];
    int      mismatch_count;
    int      answers_checked;
    int      lookups_sent;
    int      inserts_sent;
    int      full_hits;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_off;
    int      quiet_cycles;
    bit      timed_out;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // lo + floor((hi - lo) * n / den) for 0 <= n < den, formed exactly in wide arithmetic.
    function automatic logic signed [CO_W-1:0] blend(input logic signed [CO_W-1:0] lo,
                                                     input logic signed [CO_W-1:0] hi,
                                                     input logic [KEY_W-1:0] n,
                                                     input logic [KEY_W-1:0] den);
        logic signed [127:0] d;
        logic signed [127:0] prod;
        logic signed [127:0] q;
        logic signed [127:0] wide_den;
        d = $signed({{96{hi[CO_W-1]}}, hi}) - $signed({{96{lo[CO_W-1]}}, lo});
        wide_den = $signed({88'd0, den});
        prod = d * $signed({88'd0, n});
        q = prod / wide_den;
        if (prod < 0 && q * wide_den != prod)
            q = q - 1;
        return CO_W'($signed({{96{lo[CO_W-1]}}, lo}) + q);
    endfunction

    function automatic int first_at_or_above(input logic [KEY_W-1:0] f);
        int i;
        i = 0;
        while (i < shadow_used && shadow_key[i] < f)
            i++;
        return i;
    endfunction

    // Applies one request to the shadow table and returns the answer it should give.
    function automatic answer_t table_response(input logic [REQ_W-1:0] kind,
                                               input logic [KEY_W-1:0] f,
                                               input logic signed [CO_W-1:0] cr,
                                               input logic signed [CO_W-1:0] ci);
        answer_t a;
        int h;
        int k;
        a = '0;
        if (kind == REQ_LOOKUP)
        begin
            if (shadow_used == 0)
                a.status = STAT_EMPTY;
            else
            begin
                h = first_at_or_above(f);
                if (h >= shadow_used)
                begin
                    a.re = shadow_re[shadow_used-1];
                    a.im = shadow_im[shadow_used-1];
                end
                else if (h == 0 || shadow_key[h] == f)
                begin
                    a.re = shadow_re[h];
                    a.im = shadow_im[h];
                end
                else if (shadow_nearest)
                begin
                    k = ((shadow_key[h] - f) < (f - shadow_key[h-1])) ? h : h - 1;
                    a.re = shadow_re[k];
                    a.im = shadow_im[k];
                end
                else
                begin
                    a.re = blend(shadow_re[h-1], shadow_re[h], f - shadow_key[h-1],
                                 shadow_key[h] - shadow_key[h-1]);
                    a.im = blend(shadow_im[h-1], shadow_im[h], f - shadow_key[h-1],
                                 shadow_key[h] - shadow_key[h-1]);
                end
            end
        end
        else if (kind == REQ_INSERT)
        begin
            h = first_at_or_above(f);
            if (h < shadow_used && shadow_key[h] == f)
            begin
                shadow_re[h] = cr;
                shadow_im[h] = ci;
            end
            else if (shadow_used >= DEPTH)
                a.status = STAT_FULL;
            else
            begin
                for (k = shadow_used; k > h; k--)
                begin
                    shadow_key[k] = shadow_key[k-1];
                    shadow_re[k] = shadow_re[k-1];
                    shadow_im[k] = shadow_im[k-1];
                end
                shadow_key[h] = f;
                shadow_re[h] = cr;
                shadow_im[h] = ci;
                shadow_used++;
            end
        end
        else if (kind == REQ_CLEAR)
            shadow_used = 0;
        a.count = CNT_W'(shadow_used);
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // Offers one request word, idling beforehand as the current sender rate asks, and
    // records the expected answer at the edge where the word is taken. The first edge
    // lets the previous word's valid drop settle; the block is busy then anyway.
    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] f,
                             input logic signed [CO_W-1:0] cr,
                             input logic signed [CO_W-1:0] ci);
        @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        req_bus.valid <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.freq_hz <= f;
        req_bus.coeff_in_real <= cr;
        req_bus.coeff_in_imag <= ci;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pending_answers.push_back(table_response(kind, f, cr, ci));
        if (kind == REQ_LOOKUP)
            lookups_sent++;
        if (kind == REQ_INSERT)
            inserts_sent++;
        if (pending_answers[$].status == STAT_FULL)
            full_hits++;
        req_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The block is idle here, so the shadow register may change at the same edge.
    task automatic write_mode(input logic nearest);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= nearest;
        @(posedge clk);
        shadow_nearest = nearest;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [CO_W-1:0] any_coeff();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            default: return $signed($urandom());
        endcase
    endfunction

    // Keys mostly sit in a narrow band so lookups land between entries, with a few
    // anywhere in the 40-bit range.
    function automatic logic [KEY_W-1:0] any_key();
        if ($urandom_range(9) == 0)
            return {8'($urandom_range(255)), $urandom()};
        return KEY_W'($urandom_range(4000));
    endfunction

    // Sampling happens on the rising edge; ready is then updated with a nonblocking
    // assignment so the block sees it settled before the next edge.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    report_mismatch("response with nothing outstanding", 64'd1, 64'd0);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    answers_checked++;
                    if (rsp_bus.coeff_out_real !== want.re)
                        report_mismatch("coeff_out_real", rsp_bus.coeff_out_real, want.re);
                    if (rsp_bus.coeff_out_imag !== want.im)
                        report_mismatch("coeff_out_imag", rsp_bus.coeff_out_imag, want.im);
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", rsp_bus.status, want.status);
                    if (rsp_bus.entry_count !== want.count)
                        report_mismatch("entry_count", rsp_bus.entry_count, want.count);
                end
            end
            rsp_bus.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: counts cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d answers outstanding",
                     pending_answers.size());
            $display("freq_indexed_coeff_interp_table_test NOT OK");
            $finish;
        end
    end

    // Extremes of every field, each request code, and the named corner cases.
    task automatic test_directed();
        write_mode(1'b0);
        send_word(REQ_LOOKUP, 40'd1000, 32'sd0, 32'sd0);            // empty table
        send_word(REQ_UNUSED, '1, '1, '1);                          // unused code
        send_word(REQ_INSERT, 40'd1000, 32'sh7fff_ffff, 32'sh8000_0000);
        send_word(REQ_INSERT, 40'd0, 32'sh8000_0000, 32'sh7fff_ffff);
        send_word(REQ_INSERT, '1, 32'sd5, -32'sd5);
        send_word(REQ_LOOKUP, 40'd0, 32'sd0, 32'sd0);               // exact, low end
        send_word(REQ_LOOKUP, '1, 32'sd0, 32'sd0);                  // exact, high end
        send_word(REQ_LOOKUP, 40'd333, 32'sd0, 32'sd0);             // widest spread
        send_word(REQ_LOOKUP, 40'd999, 32'sd0, 32'sd0);
        send_word(REQ_LOOKUP, 40'h80_0000_0000, 32'sd0, 32'sd0);
        send_word(REQ_INSERT, 40'd1000, -32'sd7, 32'sd7);           // overwrite
        send_word(REQ_LOOKUP, 40'd1000, 32'sd0, 32'sd0);
        send_word(REQ_CLEAR, 40'd1234, 32'sd1, 32'sd1);
        send_word(REQ_INSERT, 40'd100, 32'sd10, 32'sd10);
        send_word(REQ_LOOKUP, 40'd5, 32'sd0, 32'sd0);               // below the only entry
        send_word(REQ_INSERT, 40'd200, 32'sd20, -32'sd20);
        send_word(REQ_LOOKUP, 40'd300, 32'sd0, 32'sd0);             // above the last entry
        wait_drained();
        write_mode(1'b1);
        send_word(REQ_LOOKUP, 40'd150, 32'sd0, 32'sd0);             // tie goes low
        send_word(REQ_LOOKUP, 40'd151, 32'sd0, 32'sd0);
        send_word(REQ_LOOKUP, 40'd149, 32'sd0, 32'sd0);
        send_word(REQ_LOOKUP, 40'd200, 32'sd0, 32'sd0);
        wait_drained();
    endtask

    // Fills the table to the brim, then tries inserts of new and old keys and lookups on it.
    task automatic test_full_table();
        int i;
        send_word(REQ_CLEAR, 40'd0, 32'sd0, 32'sd0);
        for (i = 0; i < DEPTH; i++)
            send_word(REQ_INSERT, KEY_W'($urandom_range(63) * 64 + i), any_coeff(),
                      any_coeff());
        for (i = 0; i < 6; i++)
            send_word(REQ_INSERT, any_key(), any_coeff(), any_coeff());
        for (i = 0; i < 4; i++)
            send_word(REQ_INSERT, shadow_key[$urandom_range(DEPTH-1)], any_coeff(),
                      any_coeff());
        for (i = 0; i < 20; i++)
            send_word(REQ_LOOKUP, KEY_W'($urandom_range(4200)), 32'sd0, 32'sd0);
    endtask

    // Random traffic: mostly inserts and lookups on a small key band, with clears
    // now and then so the table swings between empty, sparse and full.
    task automatic test_random(input int words);
        int i;
        int pick;
        logic [KEY_W-1:0] f;
        for (i = 0; i < words; i++)
        begin
            pick = $urandom_range(99);
            f = any_key();
            if (pick < 3)
                send_word(REQ_CLEAR, f, any_coeff(), any_coeff());
            else if (pick < 5)
                send_word(REQ_UNUSED, f, any_coeff(), any_coeff());
            else if (pick < 45)
                send_word(REQ_INSERT, f, any_coeff(), any_coeff());
            else
                send_word(REQ_LOOKUP, f, any_coeff(), any_coeff());
        end
    endtask

    // The receiver holds off while requests keep coming, so the block backs up into
    // its input; afterwards the sender waits for every answer before going on.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(12);
        join
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_LOOKUP;
        req_bus.freq_hz = '0;
        req_bus.coeff_in_real = '0;
        req_bus.coeff_in_imag = '0;
        rsp_bus.ready = 1'b0;
        shadow_used = 0;
        shadow_nearest = 1'b0;
        mismatch_count = 0;
        answers_checked = 0;
        lookups_sent = 0;
        inserts_sent = 0;
        full_hits = 0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();

        send_idle_pct = 32;
        recv_idle_pct = 88;
        write_mode(1'b0);
        test_random(250);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 32;
        write_mode(1'b1);
        test_full_table();
        test_random(200);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(1'b0);
        test_full_table();
        test_random(250);
        test_backpressure();

        write_mode(1'b1);
        test_random(60);
        wait_drained();

        $display("checked %0d answers: %0d lookups, %0d inserts, %0d full-table refusals",
                 answers_checked, lookups_sent, inserts_sent, full_hits);
        $display("both modes, clears, overwrites and three idling profiles were exercised");
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("freq_indexed_coeff_interp_table_test OK");
        else
            $display("freq_indexed_coeff_interp_table_test NOT OK");
        $finish;
    end

endmodule
